[rtl/wes_pkg.sv]
// ----------------------------------------------------------------------------
// wes_pkg
// Shared types and constants of the wave equation stencil step.
// ----------------------------------------------------------------------------
package wes_pkg;

  // Parameter defaults
  localparam int MAX_SIZE_DEF  = 1024;
  localparam int AMP_WIDTH_DEF = 32;

  // Fixed field widths
  localparam int GRID_W     = 11;
  localparam int DAMP_W     = 17;
  localparam int COEFF_W    = 16;
  localparam int MASK_W     = 17;
  localparam int IDX_W      = 10;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  // Reset value of the grid size register
  localparam int GRID_RESET = 1024;

  // Arithmetic constants
  localparam int          MIN_SIZE   = 3;
  localparam int          Q16_SHIFT  = 16;
  localparam logic [16:0] Q16_ONE    = 17'h10000;
  localparam int          ROUND_HALF = 32768;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_SIZE      = 1'b0,
    REG_GLOBAL_DAMPING = 1'b1
  } cfg_reg_t;

  // Classification of one accepted cell
  typedef struct packed {
    logic emit_up;   // reports the cell one row above
    logic interior;  // that cell needs the stencil arithmetic
    logic emit_own;  // last row: also reports its own border cell
  } cls_t;

  localparam int CLS_W = $bits(cls_t);

  // Back-end sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_MUL,
    S_RND,
    S_EMIT1,
    S_EMIT2
  } back_state_t;

endpackage

[rtl/wes_queue.sv]
// ----------------------------------------------------------------------------
// wes_queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module wes_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         head_valid,
  output logic [W-1:0] head_data
);

  localparam int DEPTH = wes_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = $clog2(DEPTH + 1);

  logic [W-1:0]    slot [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;

  assign full       = (count == CNTW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = slot[rd_ptr];

  // Store pushed transactions
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/wes_front.sv]
// ----------------------------------------------------------------------------
// wes_front
// Accepts cells, tracks the raster position and classifies each cell.
// ----------------------------------------------------------------------------
module wes_front #(
  parameter int MAX_SIZE  = wes_pkg::MAX_SIZE_DEF,
  parameter int AMP_WIDTH = wes_pkg::AMP_WIDTH_DEF,
  parameter int CW        = $clog2(MAX_SIZE),
  parameter int ITEM_W    = 2 * AMP_WIDTH + wes_pkg::COEFF_W + wes_pkg::MASK_W
                            + 3 * CW + wes_pkg::CLS_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [AMP_WIDTH-1:0]   cur_value,
  input  logic signed [AMP_WIDTH-1:0]   prev_value,
  input  logic [wes_pkg::COEFF_W-1:0]   cell_coeff,
  input  logic [wes_pkg::MASK_W-1:0]    cell_mask,
  input  logic [wes_pkg::GRID_W-1:0]    grid_size,
  output logic                          q_push,
  output logic [ITEM_W-1:0]             q_data,
  input  logic                          q_full
);

  localparam int CMPW = (CW > wes_pkg::GRID_W) ? CW : wes_pkg::GRID_W;

  logic [CW-1:0]      row_cnt;
  logic [CW-1:0]      col_cnt;
  logic [CMPW-1:0]    g_ext;
  logic [CMPW-1:0]    n_eff;
  logic [CMPW-1:0]    nm1;
  logic [CMPW-1:0]    row_ext;
  logic [CMPW-1:0]    col_ext;
  logic               row_end;
  logic               last_row;
  logic [CW-1:0]      col_plus;
  wes_pkg::cls_t      cls;

  // Clamp the grid size into its working range
  always_comb begin
    g_ext = CMPW'(grid_size);
    if (g_ext < CMPW'(wes_pkg::MIN_SIZE)) begin
      n_eff = CMPW'(wes_pkg::MIN_SIZE);
    end else if (g_ext > CMPW'(MAX_SIZE)) begin
      n_eff = CMPW'(MAX_SIZE);
    end else begin
      n_eff = g_ext;
    end
    nm1 = n_eff - 1'b1;
  end

  // Classify the cell at the current position
  always_comb begin
    row_ext      = CMPW'(row_cnt);
    col_ext      = CMPW'(col_cnt);
    row_end      = (col_ext >= nm1);
    last_row     = (row_ext >= nm1);
    col_plus     = row_end ? '0 : col_cnt + 1'b1;
    cls.emit_up  = (row_cnt != '0);
    cls.interior = cls.emit_up && (row_cnt != CW'(1)) && (col_cnt != '0) && !row_end;
    cls.emit_own = last_row;
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign q_data   = {cls, col_plus, col_cnt, row_cnt, cell_mask, cell_coeff,
                     prev_value, cur_value};

  // Advance the raster position on each transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= '0;
      col_cnt <= '0;
    end else if (q_push) begin
      if (row_end) begin
        col_cnt <= '0;
        row_cnt <= last_row ? '0 : row_cnt + 1'b1;
      end else begin
        col_cnt <= col_cnt + 1'b1;
      end
    end
  end

endmodule

[rtl/wes_back.sv]
// ----------------------------------------------------------------------------
// wes_back
// Line stores and stencil arithmetic on one shared multiplier; emits results.
// ----------------------------------------------------------------------------
module wes_back #(
  parameter int MAX_SIZE  = wes_pkg::MAX_SIZE_DEF,
  parameter int AMP_WIDTH = wes_pkg::AMP_WIDTH_DEF,
  parameter int CW        = $clog2(MAX_SIZE),
  parameter int ITEM_W    = 2 * AMP_WIDTH + wes_pkg::COEFF_W + wes_pkg::MASK_W
                            + 3 * CW + wes_pkg::CLS_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  logic [ITEM_W-1:0]             q_data,
  output logic                          q_pop,
  input  logic [wes_pkg::DAMP_W-1:0]    global_damping,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [AMP_WIDTH-1:0]   new_value,
  output logic [wes_pkg::IDX_W-1:0]     out_row,
  output logic [wes_pkg::IDX_W-1:0]     out_col,
  output logic                          saturated,
  output logic                          last_of_run
);

  localparam int A       = AMP_WIDTH;
  localparam int VW      = A + 4;
  localparam int PRW     = VW + 18;
  localparam int O_PREV  = A;
  localparam int O_COEFF = 2 * A;
  localparam int O_MASK  = O_COEFF + wes_pkg::COEFF_W;
  localparam int O_ROW   = O_MASK + wes_pkg::MASK_W;
  localparam int O_COL   = O_ROW + CW;
  localparam int O_CPL   = O_COL + CW;
  localparam int O_CLS   = O_CPL + CW;

  // Line stores
  logic signed [A-1:0]           row_above     [MAX_SIZE];
  logic signed [A-1:0]           row_two_above [MAX_SIZE];
  logic signed [A-1:0]           prev_mem      [MAX_SIZE];
  logic [wes_pkg::COEFF_W-1:0]   coeff_mem     [MAX_SIZE];
  logic [wes_pkg::MASK_W-1:0]    mask_mem      [MAX_SIZE];

  wes_pkg::back_state_t state;
  wes_pkg::back_state_t state_next;

  // Head item fields
  logic [CW-1:0]                 head_col;
  logic [CW-1:0]                 head_cpl;

  // Latched item
  logic signed [A-1:0]           cur;
  logic signed [A-1:0]           prv_in;
  logic [wes_pkg::COEFF_W-1:0]   coeff_in;
  logic [wes_pkg::MASK_W-1:0]    mask_in;
  logic [CW-1:0]                 row;
  logic [CW-1:0]                 col;
  wes_pkg::cls_t                 cls;

  // Read data and neighbours
  logic signed [A-1:0]           rd_center;
  logic signed [A-1:0]           rd_right;
  logic signed [A-1:0]           rd_up;
  logic signed [A-1:0]           rd_prev;
  logic [wes_pkg::COEFF_W-1:0]   rd_coeff;
  logic [wes_pkg::MASK_W-1:0]    rd_mask;
  logic signed [A-1:0]           left;

  // Arithmetic
  logic signed [VW-1:0]          lap;
  logic signed [VW-1:0]          base_c;
  logic signed [VW-1:0]          base;
  logic signed [VW-1:0]          acc;
  logic signed [PRW-1:0]         prod;
  logic signed [PRW-1:0]         prod_rnd;
  logic signed [VW-1:0]          rnd;
  logic [1:0]                    step;
  logic [16:0]                   fac;
  logic [16:0]                   damp_c;
  logic [16:0]                   mask_c;
  logic                          sat_hi;
  logic                          sat_lo;
  logic signed [A-1:0]           sat_val;

  // Control strobes
  logic                          slot_free;
  logic                          load_up;
  logic                          load_own;

  assign head_col = q_data[O_COL +: CW];
  assign head_cpl = q_data[O_CPL +: CW];

  // Clamp Q1.16 factors to one
  assign damp_c = (global_damping > wes_pkg::Q16_ONE) ? wes_pkg::Q16_ONE : global_damping;
  assign mask_c = (rd_mask > wes_pkg::Q16_ONE) ? wes_pkg::Q16_ONE : rd_mask;

  // Five-point Laplacian and the time-step base term
  always_comb begin
    lap = VW'(rd_up) + VW'(cur) + VW'(left) + VW'(rd_right) - (VW'(rd_center) <<< 2);
    base_c = (VW'(rd_center) <<< 1) - VW'(rd_prev);
  end

  // Pick the factor of the current product
  always_comb begin
    case (step)
      2'd0:    fac = 17'(rd_coeff);
      2'd1:    fac = damp_c;
      default: fac = mask_c;
    endcase
  end

  // Round to nearest, ties up, after the Q16 product
  always_comb begin
    prod_rnd = prod + PRW'(wes_pkg::ROUND_HALF);
    rnd      = VW'(prod_rnd >>> wes_pkg::Q16_SHIFT);
  end

  // Saturate the final value to the amplitude width
  always_comb begin
    sat_hi = acc > $signed({5'b0, {(A-1){1'b1}}});
    sat_lo = acc < $signed({5'b11111, {(A-1){1'b0}}});
    if (sat_hi) begin
      sat_val = $signed({1'b0, {(A-1){1'b1}}});
    end else if (sat_lo) begin
      sat_val = $signed({1'b1, {(A-1){1'b0}}});
    end else begin
      sat_val = acc[A-1:0];
    end
  end

  assign slot_free = !out_valid || !out_stall;

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wes_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and strobes
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    load_up    = 1'b0;
    load_own   = 1'b0;
    unique case (state)
      wes_pkg::S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = wes_pkg::S_SUM;
        end
      end
      wes_pkg::S_SUM: begin
        if (cls.interior) begin
          state_next = wes_pkg::S_MUL;
        end else if (cls.emit_up || cls.emit_own) begin
          state_next = wes_pkg::S_EMIT1;
        end else begin
          state_next = wes_pkg::S_IDLE;
        end
      end
      wes_pkg::S_MUL: begin
        state_next = wes_pkg::S_RND;
      end
      wes_pkg::S_RND: begin
        state_next = (step == 2'd2) ? wes_pkg::S_EMIT1 : wes_pkg::S_MUL;
      end
      wes_pkg::S_EMIT1: begin
        if (!cls.emit_up) begin
          state_next = cls.emit_own ? wes_pkg::S_EMIT2 : wes_pkg::S_IDLE;
        end else if (slot_free) begin
          load_up    = 1'b1;
          state_next = cls.emit_own ? wes_pkg::S_EMIT2 : wes_pkg::S_IDLE;
        end
      end
      wes_pkg::S_EMIT2: begin
        if (slot_free) begin
          load_own   = 1'b1;
          state_next = wes_pkg::S_IDLE;
        end
      end
      default: state_next = wes_pkg::S_IDLE;
    endcase
  end

  // Latch the popped item and read the line stores
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur       <= q_data[0 +: A];
      prv_in    <= q_data[O_PREV +: A];
      coeff_in  <= q_data[O_COEFF +: wes_pkg::COEFF_W];
      mask_in   <= q_data[O_MASK +: wes_pkg::MASK_W];
      row       <= q_data[O_ROW +: CW];
      col       <= head_col;
      cls       <= q_data[O_CLS +: wes_pkg::CLS_W];
      rd_center <= row_above[head_col];
      rd_right  <= row_above[head_cpl];
      rd_up     <= row_two_above[head_col];
      rd_prev   <= prev_mem[head_col];
      rd_coeff  <= coeff_mem[head_col];
      rd_mask   <= mask_mem[head_col];
    end
  end

  // Shift the line stores and hold the left neighbour
  always_ff @(posedge clk) begin
    if (state == wes_pkg::S_SUM) begin
      row_two_above[col] <= rd_center;
      row_above[col]     <= cur;
      prev_mem[col]      <= prv_in;
      coeff_mem[col]     <= coeff_in;
      mask_mem[col]      <= mask_in;
      left               <= rd_center;
    end
  end

  // Run the three Q16 products on the shared multiplier
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else begin
      case (state)
        wes_pkg::S_SUM: begin
          acc  <= lap;
          base <= base_c;
          step <= '0;
        end
        wes_pkg::S_MUL: begin
          prod <= acc * $signed({1'b0, fac});
        end
        wes_pkg::S_RND: begin
          acc  <= (step == 2'd0) ? base + rnd : rnd;
          step <= step + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_up || load_own) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_up) begin
      new_value   <= cls.interior ? sat_val : '0;
      saturated   <= cls.interior && (sat_hi || sat_lo);
      out_row     <= wes_pkg::IDX_W'(row - 1'b1);
      out_col     <= wes_pkg::IDX_W'(col);
      last_of_run <= !cls.emit_own;
    end else if (load_own) begin
      new_value   <= '0;
      saturated   <= 1'b0;
      out_row     <= wes_pkg::IDX_W'(row);
      out_col     <= wes_pkg::IDX_W'(col);
      last_of_run <= 1'b1;
    end
  end

  // A clipped result sits at one end of the range
  a_sat_extreme: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |->
      (new_value == $signed({1'b0, {(A-1){1'b1}}})
       || new_value == $signed({1'b1, {(A-1){1'b0}}})))
    else $error("saturated result not at range limit");

  // Stencil sum only directly after a pop
  a_sum_after_pop: assert property (@(posedge clk) disable iff (rst)
    (state == wes_pkg::S_SUM) |-> $past(q_pop))
    else $error("stencil sum without a popped item");

  // The own-row result is a zero that closes the run
  a_own_zero: assert property (@(posedge clk) disable iff (rst)
    load_own |=> (out_valid && new_value == '0 && last_of_run && !saturated))
    else $error("last-row border result malformed");

  // The multiplier step never passes the third product
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == wes_pkg::S_MUL || state == wes_pkg::S_RND) |-> (step <= 2'd2))
    else $error("product step out of range");

endmodule

[rtl/wave_equation_stencil_step.sv]
// ----------------------------------------------------------------------------
// wave_equation_stencil_step
// One explicit step of the 2-D wave equation with a five-point Laplacian.
// ----------------------------------------------------------------------------
// Cells enter in raster order; each cell below the first row reports the cell
// one row above it, so results lag one row, and a last-row cell also reports
// its own border cell as zero. The front end takes one cell per cycle into a
// two-entry queue while that queue is not full; the back end handles one cell
// at a time. For an interior cell the back end runs three Q16 products
// (Laplacian times coefficient, global damping, cell mask) one after another
// on a single multiplier, each followed by a rounding step; an output stall
// holds the back end. The line stores need no clearing pass.
module wave_equation_stencil_step #(
  parameter int MAX_SIZE  = wes_pkg::MAX_SIZE_DEF,
  parameter int AMP_WIDTH = wes_pkg::AMP_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // Cell input
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [AMP_WIDTH-1:0]      cur_value,
  input  logic signed [AMP_WIDTH-1:0]      prev_value,
  input  logic [wes_pkg::COEFF_W-1:0]      cell_coeff,
  input  logic [wes_pkg::MASK_W-1:0]       cell_mask,
  // Result output
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [AMP_WIDTH-1:0]      new_value,
  output logic [wes_pkg::IDX_W-1:0]        out_row,
  output logic [wes_pkg::IDX_W-1:0]        out_col,
  output logic                             saturated,
  output logic                             last_of_run,
  // Configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [wes_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wes_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CW     = $clog2(MAX_SIZE);
  localparam int ITEM_W = 2 * AMP_WIDTH + wes_pkg::COEFF_W + wes_pkg::MASK_W
                          + 3 * CW + wes_pkg::CLS_W;

  logic [wes_pkg::GRID_W-1:0] grid_size;
  logic [wes_pkg::DAMP_W-1:0] global_damping;
  logic                       q_push;
  logic [ITEM_W-1:0]          q_push_data;
  logic                       q_full;
  logic                       q_pop;
  logic                       q_valid;
  logic [ITEM_W-1:0]          q_head;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size      <= wes_pkg::GRID_W'(wes_pkg::GRID_RESET);
      global_damping <= wes_pkg::Q16_ONE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (wes_pkg::cfg_reg_t'(cfg_index))
        wes_pkg::REG_GRID_SIZE:      grid_size      <= cfg_data[wes_pkg::GRID_W-1:0];
        wes_pkg::REG_GLOBAL_DAMPING: global_damping <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  wes_front #(
    .MAX_SIZE  (MAX_SIZE),
    .AMP_WIDTH (AMP_WIDTH),
    .CW        (CW),
    .ITEM_W    (ITEM_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cur_value  (cur_value),
    .prev_value (prev_value),
    .cell_coeff (cell_coeff),
    .cell_mask  (cell_mask),
    .grid_size  (grid_size),
    .q_push     (q_push),
    .q_data     (q_push_data),
    .q_full     (q_full)
  );

  wes_queue #(
    .W (ITEM_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  wes_back #(
    .MAX_SIZE  (MAX_SIZE),
    .AMP_WIDTH (AMP_WIDTH),
    .CW        (CW),
    .ITEM_W    (ITEM_W)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_data         (q_head),
    .q_pop          (q_pop),
    .global_damping (global_damping),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .new_value      (new_value),
    .out_row        (out_row),
    .out_col        (out_col),
    .saturated      (saturated),
    .last_of_run    (last_of_run)
  );

endmodule
